// ===== rtl/core/lrpw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the line raster pixel writer.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package lrpw_pkg;

    localparam int FIELD_BITS     = 12;
    localparam int COLOR_BITS     = 32;
    localparam int ADDR_BITS      = 32;
    localparam int PITCH_BITS     = 15;
    localparam int BPP_BITS       = 3;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [ADDR_BITS-1:0]  BASE_RESET  = '0;
    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 15'd4096;
    localparam logic [BPP_BITS-1:0]   BPP_RESET   = 3'd4;

    // Command codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Register map, word index within the APB window
    typedef enum logic [1:0] {
        REG_FRAME_BASE      = 2'd0,
        REG_LINE_PITCH      = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2,
        REG_BIG_ENDIAN      = 2'd3
    } t_reg;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  frame_base;
        logic [PITCH_BITS-1:0] line_pitch;
        logic [BPP_BITS-1:0]   bytes_per_pixel;
        logic                  big_endian;
    } t_cfg;

endpackage

// ===== rtl/core/lrpw_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the command and pixel channels.
// Depends on lrpw_pkg for field widths.
interface lrpw_cmd_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [lrpw_pkg::FIELD_BITS-1:0]  start_x;
    logic [lrpw_pkg::FIELD_BITS-1:0]  start_y;
    logic [lrpw_pkg::FIELD_BITS-1:0]  end_x;
    logic [lrpw_pkg::FIELD_BITS-1:0]  end_y;
    logic [lrpw_pkg::COLOR_BITS-1:0]  color;

    modport source (output valid, func, start_x, start_y, end_x, end_y, color,
                    input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, color,
                    output ready);
endinterface

interface lrpw_pix_if;
    logic                             valid;
    logic                             ready;
    logic [lrpw_pkg::ADDR_BITS-1:0]   pixel_addr;
    logic [lrpw_pkg::COLOR_BITS-1:0]  pixel_bytes;
    logic [lrpw_pkg::FIELD_BITS-1:0]  pixel_x;
    logic [lrpw_pkg::FIELD_BITS-1:0]  pixel_y;
    logic                             last;

    modport source (output valid, pixel_addr, pixel_bytes, pixel_x, pixel_y, last,
                    input ready);
    modport sink   (input valid, pixel_addr, pixel_bytes, pixel_x, pixel_y, last,
                    output ready);
endinterface

// ===== rtl/core/lrpw_line_step.sv =====
`timescale 1ns / 1ps
// Bresenham line state and stepper: loads a line, emits one pixel record per step.
// Depends on lrpw_pkg.
module lrpw_line_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_func,
    input  logic [lrpw_pkg::FIELD_BITS-1:0]  i_start_x,
    input  logic [lrpw_pkg::FIELD_BITS-1:0]  i_start_y,
    input  logic [lrpw_pkg::FIELD_BITS-1:0]  i_end_x,
    input  logic [lrpw_pkg::FIELD_BITS-1:0]  i_end_y,
    input  logic [lrpw_pkg::COLOR_BITS-1:0]  i_color,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [COORD_BITS-1:0]            o_x,
    output logic [COORD_BITS-1:0]            o_y,
    output logic [lrpw_pkg::COLOR_BITS-1:0]  o_color,
    output logic                             o_last
);

    localparam int DW = COORD_BITS + 1;   // signed coordinate difference
    localparam int EW = COORD_BITS + 4;   // signed error term

    function automatic logic [COORD_BITS-1:0] step_coord(
        input logic [COORD_BITS-1:0] c,
        input logic                  neg
    );
        return neg ? c - 1'b1 : c + 1'b1;
    endfunction

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_stop_x, r_stop_y;
    logic [COORD_BITS-1:0] r_dmaj, r_dmin;
    logic [EW-1:0]         r_err;
    logic                  r_xmaj, r_xneg, r_yneg, r_active;
    logic [lrpw_pkg::COLOR_BITS-1:0] r_color;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [lrpw_pkg::COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    // Load path
    logic [COORD_BITS-1:0] ld_sx, ld_sy, ld_ex, ld_ey;
    logic [DW-1:0]         ld_dx, ld_dy;
    logic [COORD_BITS-1:0] ld_adx, ld_ady, ld_dmaj, ld_dmin;
    logic                  ld_xneg, ld_yneg, ld_xmaj;
    logic [EW-1:0]         ld_err;

    // Step path
    logic                  minor_go;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic [EW-1:0]         n_err;
    logic                  n_fin;
    logic                  accept;

    always_comb begin
        ld_sx   = COORD_BITS'(i_start_x);
        ld_sy   = COORD_BITS'(i_start_y);
        ld_ex   = COORD_BITS'(i_end_x);
        ld_ey   = COORD_BITS'(i_end_y);
        ld_dx   = {1'b0, ld_ex} - {1'b0, ld_sx};
        ld_dy   = {1'b0, ld_ey} - {1'b0, ld_sy};
        ld_xneg = ld_dx[DW-1] || (ld_dx == '0);
        ld_yneg = ld_dy[DW-1] || (ld_dy == '0);
        ld_adx  = ld_dx[DW-1] ? COORD_BITS'(-ld_dx) : COORD_BITS'(ld_dx);
        ld_ady  = ld_dy[DW-1] ? COORD_BITS'(-ld_dy) : COORD_BITS'(ld_dy);
        ld_xmaj = ld_adx > ld_ady;
        ld_dmaj = ld_xmaj ? ld_adx : ld_ady;
        ld_dmin = ld_xmaj ? ld_ady : ld_adx;
        ld_err  = EW'({ld_dmin, 1'b0}) - EW'(ld_dmaj);
    end

    always_comb begin
        minor_go = !r_err[EW-1];
        n_err    = r_err + EW'({r_dmin, 1'b0})
                 - (minor_go ? EW'({r_dmaj, 1'b0}) : '0);
        if (r_xmaj) begin
            n_cur_x = step_coord(r_cur_x, r_xneg);
            n_cur_y = minor_go ? step_coord(r_cur_y, r_yneg) : r_cur_y;
            n_fin   = (n_cur_x == r_stop_x);
        end else begin
            n_cur_x = minor_go ? step_coord(r_cur_x, r_xneg) : r_cur_x;
            n_cur_y = step_coord(r_cur_y, r_yneg);
            n_fin   = (n_cur_y == r_stop_y);
        end
    end

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_stop_x    <= '0;
            r_stop_y    <= '0;
            r_dmaj      <= '0;
            r_dmin      <= '0;
            r_err       <= '0;
            r_xmaj      <= 1'b0;
            r_xneg      <= 1'b0;
            r_yneg      <= 1'b0;
            r_color     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_func == lrpw_pkg::FUNC_STEP) && r_active) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (i_func == lrpw_pkg::FUNC_LOAD) begin
                    r_cur_x  <= ld_sx;
                    r_cur_y  <= ld_sy;
                    r_stop_x <= ld_ex;
                    r_stop_y <= ld_ey;
                    r_dmaj   <= ld_dmaj;
                    r_dmin   <= ld_dmin;
                    r_err    <= ld_err;
                    r_xmaj   <= ld_xmaj;
                    r_xneg   <= ld_xneg;
                    r_yneg   <= ld_yneg;
                    r_color  <= i_color;
                    r_active <= (ld_dmaj != '0);
                end else if (r_active) begin
                    r_cur_x     <= n_cur_x;
                    r_cur_y     <= n_cur_y;
                    r_err       <= n_err;
                    r_active    <= !n_fin;
                end
            end
        end
    end

    // Pixel record: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (accept && (i_func == lrpw_pkg::FUNC_STEP) && r_active) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_color <= r_color;
            r_out_last  <= n_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_out_x;
    assign o_y     = r_out_y;
    assign o_color = r_out_color;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/core/lrpw_pixel_pack.sv =====
`timescale 1ns / 1ps
// Address and byte-lane packing of one pixel record into the output register.
// Depends on lrpw_pkg (t_cfg and field widths).
module lrpw_pixel_pack #(
    parameter int COORD_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lrpw_pkg::t_cfg                   i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [COORD_BITS-1:0]            i_x,
    input  logic [COORD_BITS-1:0]            i_y,
    input  logic [lrpw_pkg::COLOR_BITS-1:0]  i_color,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lrpw_pkg::ADDR_BITS-1:0]   o_addr,
    output logic [lrpw_pkg::COLOR_BITS-1:0]  o_bytes,
    output logic [lrpw_pkg::FIELD_BITS-1:0]  o_x,
    output logic [lrpw_pkg::FIELD_BITS-1:0]  o_y,
    output logic                             o_last
);

    localparam int YOFF_BITS = COORD_BITS + lrpw_pkg::PITCH_BITS;
    localparam int XOFF_BITS = COORD_BITS + lrpw_pkg::BPP_BITS;

    // Byte k of the result takes color byte k, or byte n-1-k in big-endian order
    function automatic logic [lrpw_pkg::COLOR_BITS-1:0] pack_color(
        input logic [lrpw_pkg::COLOR_BITS-1:0] col,
        input logic [2:0]                      n,
        input logic                            big
    );
        logic [lrpw_pkg::COLOR_BITS-1:0] res;
        logic [1:0]                      src;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            src = big ? 2'(n - 3'(k) - 3'd1) : 2'(k);
            if (3'(k) < n) begin
                res[8*k +: 8] = col[8*src +: 8];
            end
        end
        return res;
    endfunction

    logic [2:0]                        nbytes;
    logic [YOFF_BITS-1:0]              y_off;
    logic [XOFF_BITS-1:0]              x_off;
    logic [lrpw_pkg::ADDR_BITS-1:0]    n_addr;
    logic                              accept;

    logic                              r_valid;
    logic [lrpw_pkg::ADDR_BITS-1:0]    r_addr;
    logic [lrpw_pkg::COLOR_BITS-1:0]   r_bytes;
    logic [lrpw_pkg::FIELD_BITS-1:0]   r_x, r_y;
    logic                              r_last;

    always_comb begin
        if (i_cfg.bytes_per_pixel == 3'd0) begin
            nbytes = 3'd1;
        end else if (i_cfg.bytes_per_pixel > 3'd4) begin
            nbytes = 3'd4;
        end else begin
            nbytes = i_cfg.bytes_per_pixel;
        end
    end

    assign y_off  = i_y * i_cfg.line_pitch;
    assign x_off  = i_x * nbytes;
    assign n_addr = i_cfg.frame_base + lrpw_pkg::ADDR_BITS'(y_off)
                  + lrpw_pkg::ADDR_BITS'(x_off);

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= n_addr;
            r_bytes <= pack_color(i_color, nbytes, i_cfg.big_endian);
            r_x     <= lrpw_pkg::FIELD_BITS'(i_x);
            r_y     <= lrpw_pkg::FIELD_BITS'(i_y);
            r_last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_bytes = r_bytes;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/line_raster_pixel_writer_core.sv =====
`timescale 1ns / 1ps
// Line raster pixel writer: Bresenham stepper plus frame buffer address/byte packing.
// Depends on lrpw_pkg, lrpw_stream_if, lrpw_line_step and lrpw_pixel_pack.
//
// Usage:
//   i_cmd carries commands. func = load takes two endpoints and a color and
//   gives no pixel; func = step emits the next pixel of the current line, or
//   nothing when no line is active. The end point is never drawn.
//   o_pix carries pixels: byte address, color bytes in memory order,
//   coordinates and a last flag on the final pixel of the line.
//   The APB port sets frame_base (0x0), line_pitch (0x4), bytes_per_pixel
//   (0x8) and big_endian (0xC); write it only while the block is idle.
// Timing:
//   One command per clock while i_cmd.ready is high. An accepted step's pixel passes
//   through the stepper register and then the output register (address
//   multiply-add and packing) before it shows on o_pix.
// Reset (synchronous, active low) drops any line, empties both stages and
//   returns the registers to base 0, pitch 4096, 4 bytes, little endian.
// Stall: with o_pix.ready low both stages fill and i_cmd.ready falls; a
//   waiting pixel holds until taken.
module line_raster_pixel_writer_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lrpw_cmd_if.sink                            i_cmd,
    lrpw_pix_if.source                          o_pix,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrpw_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [lrpw_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [lrpw_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    lrpw_pkg::t_cfg r_cfg;
    lrpw_pkg::t_reg reg_sel;
    logic           cfg_wr;

    logic                             step_valid, step_ready, step_last;
    logic [COORD_BITS-1:0]            step_x, step_y;
    logic [lrpw_pkg::COLOR_BITS-1:0]  step_color;

    assign pready  = 1'b1;
    assign reg_sel = lrpw_pkg::t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base      <= lrpw_pkg::BASE_RESET;
            r_cfg.line_pitch      <= lrpw_pkg::PITCH_RESET;
            r_cfg.bytes_per_pixel <= lrpw_pkg::BPP_RESET;
            r_cfg.big_endian      <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                lrpw_pkg::REG_FRAME_BASE: begin
                    r_cfg.frame_base <= pwdata;
                end
                lrpw_pkg::REG_LINE_PITCH: begin
                    r_cfg.line_pitch <= pwdata[lrpw_pkg::PITCH_BITS-1:0];
                end
                lrpw_pkg::REG_BYTES_PER_PIXEL: begin
                    r_cfg.bytes_per_pixel <= pwdata[lrpw_pkg::BPP_BITS-1:0];
                end
                lrpw_pkg::REG_BIG_ENDIAN: begin
                    r_cfg.big_endian <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            lrpw_pkg::REG_FRAME_BASE:      prdata = r_cfg.frame_base;
            lrpw_pkg::REG_LINE_PITCH:      prdata = 32'(r_cfg.line_pitch);
            lrpw_pkg::REG_BYTES_PER_PIXEL: prdata = 32'(r_cfg.bytes_per_pixel);
            lrpw_pkg::REG_BIG_ENDIAN:      prdata = 32'(r_cfg.big_endian);
            default:                       prdata = '0;
        endcase
    end

    lrpw_line_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .o_ready   (i_cmd.ready),
        .i_func    (i_cmd.func),
        .i_start_x (i_cmd.start_x),
        .i_start_y (i_cmd.start_y),
        .i_end_x   (i_cmd.end_x),
        .i_end_y   (i_cmd.end_y),
        .i_color   (i_cmd.color),
        .o_valid   (step_valid),
        .i_ready   (step_ready),
        .o_x       (step_x),
        .o_y       (step_y),
        .o_color   (step_color),
        .o_last    (step_last)
    );

    lrpw_pixel_pack #(
        .COORD_BITS (COORD_BITS)
    ) u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (step_valid),
        .o_ready (step_ready),
        .i_x     (step_x),
        .i_y     (step_y),
        .i_color (step_color),
        .i_last  (step_last),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_addr  (o_pix.pixel_addr),
        .o_bytes (o_pix.pixel_bytes),
        .o_x     (o_pix.pixel_x),
        .o_y     (o_pix.pixel_y),
        .o_last  (o_pix.last)
    );

endmodule

// ===== rtl/core/lrpw_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for line_raster_pixel_writer_core, attached by bind.
// Depends on lrpw_pkg for widths and register indexes.
module lrpw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    input  logic                                i_cmd_ready,
    input  logic                                i_pix_valid,
    input  logic                                i_pix_ready,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [lrpw_pkg::APB_ADDR_BITS-1:0]  i_paddr,
    input  logic [lrpw_pkg::APB_DATA_BITS-1:0]  i_pwdata,
    input  logic [lrpw_pkg::APB_DATA_BITS-1:0]  i_prdata
);

    logic cmd_acc;
    logic base_wr;
    logic base_rd;

    assign cmd_acc = i_cmd_valid && i_cmd_ready;
    assign base_wr = i_psel && i_penable && i_pwrite
                  && (i_paddr[3:2] == lrpw_pkg::REG_FRAME_BASE);
    assign base_rd = (i_paddr[3:2] == lrpw_pkg::REG_FRAME_BASE);

    // A stalled pixel transaction stays offered
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid)
        else $error("pixel valid dropped while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel valid after reset");

    // Idle input with the sink ready drains the stepper stage and then the output stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(cmd_acc) && !$past(cmd_acc, 2) && $past(i_pix_ready)
         && $past(i_pix_ready, 2)) |-> !i_pix_valid)
        else $error("pixel appeared without a command");

    // Frame base reads back what was written
    a_base_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(base_wr) && $past(i_rst_n) && base_rd |-> i_prdata == $past(i_pwdata))
        else $error("frame_base readback mismatch");

endmodule

bind line_raster_pixel_writer_core lrpw_checker u_lrpw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for line_raster_pixel_writer_core: Bresenham walk, pixel address
// and byte packing checked against an in-bench line walker. Needs lrpw_pkg, the stream
// interfaces and the core RTL.
module tb_top;

    localparam int COORD_BITS    = lrpw_pkg::FIELD_BITS;
    localparam int FB            = lrpw_pkg::FIELD_BITS;
    localparam int CB            = lrpw_pkg::COLOR_BITS;
    localparam int LATENCY       = 2;
    localparam int SETTLE_CYCLES = LATENCY + 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 80;

    typedef struct packed {
        logic [lrpw_pkg::ADDR_BITS-1:0]  addr;
        logic [lrpw_pkg::COLOR_BITS-1:0] bytes;
        logic [lrpw_pkg::FIELD_BITS-1:0] x;
        logic [lrpw_pkg::FIELD_BITS-1:0] y;
        logic                            last;
    } t_pixel;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [lrpw_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [lrpw_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [lrpw_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    lrpw_cmd_if cmd_bus ();
    lrpw_pix_if pix_bus ();

    line_raster_pixel_writer_core #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_pix   (pix_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic cmd_fire;
    logic pix_fire;
    assign cmd_fire = cmd_bus.valid & cmd_bus.ready;
    assign pix_fire = pix_bus.valid & pix_bus.ready;

    // Line walker state and pixel format
    lrpw_pkg::t_cfg        fmt;
    logic [FB-1:0]         walk_x, walk_y, walk_stop_x, walk_stop_y;
    int                    walk_dmaj, walk_dmin, walk_err;
    bit                    walk_x_major, walk_x_neg, walk_y_neg, walk_active;
    logic [CB-1:0]         walk_color;

    t_pixel pending_pixels[$];

    int idle_pct      = 34;
    int hold_request  = 0;
    int error_count   = 0;
    int loads_sent    = 0;
    int idle_steps    = 0;
    int pixels_expected = 0;
    int pixels_checked  = 0;
    int formats_used    = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------- line walker
    function automatic void walker_reset();
        fmt.frame_base      = lrpw_pkg::BASE_RESET;
        fmt.line_pitch      = lrpw_pkg::PITCH_RESET;
        fmt.bytes_per_pixel = lrpw_pkg::BPP_RESET;
        fmt.big_endian      = 1'b0;
        walk_x = '0; walk_y = '0; walk_stop_x = '0; walk_stop_y = '0;
        walk_dmaj = 0; walk_dmin = 0; walk_err = 0;
        walk_x_major = 1'b0; walk_x_neg = 1'b0; walk_y_neg = 1'b0;
        walk_color = '0;
        walk_active = 1'b0;
    endfunction

    function automatic void format_write(lrpw_pkg::t_reg r, logic [31:0] v);
        case (r)
            lrpw_pkg::REG_FRAME_BASE:      fmt.frame_base = v;
            lrpw_pkg::REG_LINE_PITCH:      fmt.line_pitch = v[lrpw_pkg::PITCH_BITS-1:0];
            lrpw_pkg::REG_BYTES_PER_PIXEL: fmt.bytes_per_pixel = v[lrpw_pkg::BPP_BITS-1:0];
            lrpw_pkg::REG_BIG_ENDIAN:      fmt.big_endian = v[0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] format_read(lrpw_pkg::t_reg r);
        case (r)
            lrpw_pkg::REG_FRAME_BASE:      return fmt.frame_base;
            lrpw_pkg::REG_LINE_PITCH:      return 32'(fmt.line_pitch);
            lrpw_pkg::REG_BYTES_PER_PIXEL: return 32'(fmt.bytes_per_pixel);
            default:                       return 32'(fmt.big_endian);
        endcase
    endfunction

    function automatic logic [31:0] format_mask(lrpw_pkg::t_reg r);
        case (r)
            lrpw_pkg::REG_FRAME_BASE:      return 32'hFFFF_FFFF;
            lrpw_pkg::REG_LINE_PITCH:      return 32'h0000_7FFF;
            lrpw_pkg::REG_BYTES_PER_PIXEL: return 32'h0000_0007;
            default:                       return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [FB-1:0] next_coord(logic [FB-1:0] c, bit neg);
        return neg ? c - 1'b1 : c + 1'b1;
    endfunction

    function automatic void line_load(logic [FB-1:0] sx, sy, ex, ey,
                                      logic [CB-1:0] color);
        int dx, dy;
        walk_x      = sx;
        walk_y      = sy;
        walk_stop_x = ex;
        walk_stop_y = ey;
        walk_color  = color;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        walk_x_neg = !(dx > 0);
        walk_y_neg = !(dy > 0);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        walk_x_major = dx > dy;
        walk_dmaj = walk_x_major ? dx : dy;
        walk_dmin = walk_x_major ? dy : dx;
        walk_err  = 2 * walk_dmin - walk_dmaj;
        walk_active = walk_dmaj != 0;
    endfunction

    // Advance one pixel along the current line; 0 when no line is active
    function automatic bit bresenham_advance(output t_pixel px);
        logic [FB-1:0] ox, oy;
        int  nbytes, src;
        bit  done;
        px = '0;
        if (!walk_active) return 1'b0;
        ox = walk_x;
        oy = walk_y;
        if (walk_err >= 0) begin
            if (walk_x_major) walk_y = next_coord(walk_y, walk_y_neg);
            else              walk_x = next_coord(walk_x, walk_x_neg);
            walk_err -= 2 * walk_dmaj;
        end
        walk_err += 2 * walk_dmin;
        if (walk_x_major) begin
            walk_x = next_coord(walk_x, walk_x_neg);
            done = walk_x == walk_stop_x;
        end else begin
            walk_y = next_coord(walk_y, walk_y_neg);
            done = walk_y == walk_stop_y;
        end
        if (done) walk_active = 1'b0;

        // out-of-range pixel sizes clamp to 1..4
        if (fmt.bytes_per_pixel == 0)     nbytes = 1;
        else if (fmt.bytes_per_pixel > 4) nbytes = 4;
        else                              nbytes = int'(fmt.bytes_per_pixel);

        px.addr = fmt.frame_base + oy * fmt.line_pitch + ox * nbytes;
        for (int k = 0; k < nbytes; k++) begin
            src = fmt.big_endian ? nbytes - 1 - k : k;
            px.bytes[8*k +: 8] = walk_color[8*src +: 8];
        end
        px.x    = ox;
        px.y    = oy;
        px.last = done;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- command side
    // Call at a rising edge; returns at the edge that accepts the transaction
    task automatic send_cmd(logic func, logic [FB-1:0] sx, sy, ex, ey,
                            logic [CB-1:0] color);
        int     gap;
        t_pixel px;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.func    <= func;
        cmd_bus.start_x <= sx;
        cmd_bus.start_y <= sy;
        cmd_bus.end_x   <= ex;
        cmd_bus.end_y   <= ey;
        cmd_bus.color   <= color;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        if (func == lrpw_pkg::FUNC_LOAD) begin
            line_load(sx, sy, ex, ey, color);
            loads_sent++;
        end else if (bresenham_advance(px)) begin
            pending_pixels.push_back(px);
            pixels_expected++;
        end else begin
            idle_steps++;
        end
    endtask

    task automatic load_line(int sx, int sy, int ex, int ey, logic [CB-1:0] color);
        send_cmd(lrpw_pkg::FUNC_LOAD, FB'(sx), FB'(sy), FB'(ex), FB'(ey), color);
    endtask

    // Step fields are don't-care; fill them with noise
    task automatic step_line(int count);
        repeat (count) send_cmd(lrpw_pkg::FUNC_STEP, FB'($urandom), FB'($urandom),
                                FB'($urandom), FB'($urandom), $urandom);
    endtask

    // Stop offering commands, wait out every pixel, then let the pipe settle
    task automatic drain_pixels();
        cmd_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- register port
    task automatic apb_write(lrpw_pkg::t_reg r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        format_write(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check(lrpw_pkg::t_reg r);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        if ((got & format_mask(r)) !== format_read(r))
            report_error($sformatf("register %s read %h, expected %h",
                                   r.name(), got & format_mask(r), format_read(r)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_registers();
        apb_check(lrpw_pkg::REG_FRAME_BASE);
        apb_check(lrpw_pkg::REG_LINE_PITCH);
        apb_check(lrpw_pkg::REG_BYTES_PER_PIXEL);
        apb_check(lrpw_pkg::REG_BIG_ENDIAN);
    endtask

    task automatic apply_format(logic [31:0] base, logic [lrpw_pkg::PITCH_BITS-1:0] pitch,
                                logic [lrpw_pkg::BPP_BITS-1:0] bpp, logic big);
        drain_pixels();
        apb_write(lrpw_pkg::REG_FRAME_BASE, base);
        apb_write(lrpw_pkg::REG_LINE_PITCH, 32'(pitch));
        apb_write(lrpw_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
        apb_write(lrpw_pkg::REG_BIG_ENDIAN, 32'(big));
        check_registers();
        formats_used++;
    endtask

    function automatic logic [lrpw_pkg::PITCH_BITS-1:0] random_pitch();
        return lrpw_pkg::PITCH_BITS'($urandom_range(0, 16384));
    endfunction

    // ---------------------------------------------------------------- random lines
    function automatic int near_coord(int c);
        int off;
        off = int'($urandom_range(0, 40)) - 20;
        if (c + off > 4095 || c + off < 0) return c - off;
        return c + off;
    endfunction

    // Mostly complete short lines; some cut short, some far lines, some noise
    task automatic run_line_mix(int n);
        int goal, kind, sx, sy, ex, ey, span;
        goal = loads_sent + pixels_expected + n;
        while (loads_sent + pixels_expected < goal) begin
            kind = $urandom_range(0, 99);
            sx = $urandom_range(0, 4095);
            sy = $urandom_range(0, 4095);
            if (kind < 8) begin
                send_cmd(1'($urandom_range(0, 1)), FB'($urandom), FB'($urandom),
                         FB'($urandom), FB'($urandom), $urandom);
            end else if (kind < 14) begin
                load_line(sx, sy, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
                step_line($urandom_range(0, 5));
            end else begin
                ex = near_coord(sx);
                ey = near_coord(sy);
                span = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;
                load_line(sx, sy, ex, ey, $urandom);
                if (kind < 20) step_line($urandom_range(0, span));
                else           step_line(span + $urandom_range(0, 1));
            end
        end
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed_lines();
        check_registers();
        // step with no line, then a zero-length line
        step_line(1);
        load_line(7, 7, 7, 7, 32'h0000_0000);
        step_line(1);
        // shallow x-major line up to end row 0, one step past its end
        load_line(0, 2, 3, 0, 32'hFFFF_FFFF);
        step_line(4);
        // steep line walking down and left from the far corner
        load_line(4095, 4095, 4093, 4090, 32'h1234_5678);
        step_line(5);
        // diagonal replaced mid-line by a new load
        load_line(4095, 0, 0, 4095, 32'hA5C3_0F81);
        step_line(2);
        load_line(4093, 4094, 4095, 4095, 32'h5A3C_F07E);
        step_line(2);
    endtask

    task automatic test_format_sweep();
        apply_format(32'h0000_0000, 15'd0, 3'd1, 1'b0);
        run_line_mix(35);
        apply_format(32'hFFFF_FFFF, 15'd16384, 3'd4, 1'b1);
        run_line_mix(35);
        // address wraps past the top of the space
        apply_format(32'hFFFF_F000, 15'h7FFF, 3'd0, 1'b1);
        run_line_mix(30);
        apply_format($urandom, random_pitch(), 3'd2, 1'b1);
        run_line_mix(35);
        apply_format($urandom, random_pitch(), 3'd3, 1'b0);
        run_line_mix(35);
        apply_format($urandom, random_pitch(), 3'd5, 1'b1);
        run_line_mix(30);
        apply_format($urandom, random_pitch(), 3'd6, 1'b0);
        run_line_mix(25);
        apply_format($urandom, random_pitch(), 3'd7, 1'b1);
        run_line_mix(25);
    endtask

    // Hold the pixel sink off while steps keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        load_line(10, 20, 150, 60, $urandom);
        step_line(45);
        drain_pixels();
    endtask

    task automatic test_back_to_back();
        apply_format($urandom, random_pitch(), 3'd4, 1'b0);
        idle_pct = 0;
        run_line_mix(50);
        drain_pixels();
        idle_pct = 34;
    endtask

    // ---------------------------------------------------------------- pixel side
    initial begin : pixel_sink
        int hold_left;
        hold_left = 0;
        pix_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_bus.ready <= 1'b0;
            end else begin
                pix_bus.ready <= $urandom_range(0, 99) >= idle_pct;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n === 1'b1 && pix_fire === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                report_error($sformatf("unexpected pixel x=%0d y=%0d addr=%h",
                                       pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_addr));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (pix_bus.pixel_addr !== want.addr)
                    report_error($sformatf("pixel_addr %h, expected %h",
                                           pix_bus.pixel_addr, want.addr));
                if (pix_bus.pixel_bytes !== want.bytes)
                    report_error($sformatf("pixel_bytes %h, expected %h",
                                           pix_bus.pixel_bytes, want.bytes));
                if (pix_bus.pixel_x !== want.x)
                    report_error($sformatf("pixel_x %0d, expected %0d", pix_bus.pixel_x, want.x));
                if (pix_bus.pixel_y !== want.y)
                    report_error($sformatf("pixel_y %0d, expected %0d", pix_bus.pixel_y, want.y));
                if (pix_bus.last !== want.last)
                    report_error($sformatf("last %b, expected %b at x=%0d y=%0d",
                                           pix_bus.last, want.last, want.x, want.y));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || cmd_fire === 1'b1 || pix_fire === 1'b1) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
                 STALL_LIMIT, pending_pixels.size());
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.func    <= lrpw_pkg::FUNC_STEP;
        cmd_bus.start_x <= '0;
        cmd_bus.start_y <= '0;
        cmd_bus.end_x   <= '0;
        cmd_bus.end_y   <= '0;
        cmd_bus.color   <= '0;
        walker_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_format_sweep();
        test_output_backpressure();
        test_back_to_back();
        drain_pixels();

        $display("covered %0d line loads, %0d pixels checked, %0d steps with no line,",
                 loads_sent, pixels_checked, idle_steps);
        $display("%0d formats, a %0d-cycle output stall and a stretch with no idle cycles",
                 formats_used, HOLD_CYCLES);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
